### src/multi_timer_manager_macros.svh
`ifndef MULTI_TIMER_MANAGER_MACROS_SVH
`define MULTI_TIMER_MANAGER_MACROS_SVH

// same-cycle implication
`define MTM_ASSERT_NOW(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define MTM_ASSERT_NXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

### src/mtm_pkg.sv
package mtm_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int IDX_W = 8;

    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_CREATE = 3'd1;
    localparam logic [2:0] KIND_START  = 3'd2;
    localparam logic [2:0] KIND_STOP   = 3'd3;
    localparam logic [2:0] KIND_DELETE = 3'd4;
    localparam logic [2:0] KIND_QUERY  = 3'd5;

    localparam logic [2:0] STS_OK          = 3'd0;
    localparam logic [2:0] STS_BAD_OPTION  = 3'd1;
    localparam logic [2:0] STS_NONE_FREE   = 3'd2;
    localparam logic [2:0] STS_UNUSED      = 3'd3;
    localparam logic [2:0] STS_NOT_RUNNING = 3'd4;
    localparam logic [2:0] STS_NO_CALLBACK = 3'd5;

    localparam logic [1:0] TS_UNUSED    = 2'd0;
    localparam logic [1:0] TS_STOPPED   = 2'd1;
    localparam logic [1:0] TS_RUNNING   = 2'd2;
    localparam logic [1:0] TS_COMPLETED = 2'd3;

    localparam logic [1:0] OPT_NONE   = 2'd0;
    localparam logic [1:0] OPT_NO_CB  = 2'd1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  target_id;
        logic [31:0] delay;
        logic [31:0] period;
        logic [1:0]  mode_select;
        logic        has_callback;
        logic [1:0]  stop_option;
    } item_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  timer_id_res;
        logic [1:0]  timer_state;
        logic [31:0] remaining;
        logic [1:0]  callback_use;
        logic        fired;
        logic        last;
    } item_res_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CREATE,
        OP_START,
        OP_STOP,
        OP_DELETE,
        OP_FIRE
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [IDX_W-1:0]  idx;
        logic [31:0]       delay;
        logic [31:0]       period;
        logic              periodic;
        logic              callback;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_SCAN
    } fsm_t;

endpackage

### src/mtm_cell.sv
module mtm_cell #(
    parameter int IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mtm_pkg::cell_cmd_t cmd,
    input  logic [31:0]       count,
    input  logic              pend,
    input  logic              prior_in,
    output logic              prior_out,
    output logic              sel,
    output logic              hit,
    output logic [1:0]        st,
    output logic [31:0]       match,
    output logic              periodic,
    output logic              callback
);
    import mtm_pkg::*;

    logic [1:0]  st_reg, st_next;
    logic [31:0] match_reg, match_next;
    logic [31:0] dly_reg, dly_next;
    logic [31:0] per_reg, per_next;
    logic        periodic_reg, periodic_next;
    logic        cb_reg, cb_next;
    logic        mine;
    logic [31:0] base;

    assign mine      = (cmd.idx == IDX_W'(IDX));
    assign sel       = pend && !prior_in;
    assign prior_out = prior_in || pend;
    assign hit       = (st_reg == TS_RUNNING) && (match_reg == count);
    assign st        = st_reg;
    assign match     = match_reg;
    assign periodic  = periodic_reg;
    assign callback  = cb_reg;

    always_comb
    begin
        st_next       = st_reg;
        match_next    = match_reg;
        dly_next      = dly_reg;
        per_next      = per_reg;
        periodic_next = periodic_reg;
        cb_next       = cb_reg;
        if (cmd.op == OP_CREATE)
            base = cmd.periodic ? cmd.period : cmd.delay;
        else if (cmd.op == OP_FIRE)
            base = per_reg;
        else
            base = periodic_reg ? per_reg : dly_reg;
        case (cmd.op)
            OP_CREATE:
            begin
                if (mine)
                begin
                    dly_next      = cmd.delay;
                    per_next      = cmd.period;
                    periodic_next = cmd.periodic;
                    cb_next       = cmd.callback;
                    match_next    = count + base;
                    st_next       = TS_STOPPED;
                end
            end
            OP_START:
            begin
                if (mine)
                begin
                    match_next = count + base;
                    st_next    = TS_RUNNING;
                end
            end
            OP_STOP:
            begin
                if (mine)
                    st_next = TS_STOPPED;
            end
            OP_DELETE:
            begin
                if (mine)
                    st_next = TS_UNUSED;
            end
            OP_FIRE:
            begin
                if (sel)
                begin
                    if (periodic_reg)
                        match_next = count + base;
                    else
                        st_next = TS_COMPLETED;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= TS_UNUSED;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        match_reg    <= match_next;
        dly_reg      <= dly_next;
        per_reg      <= per_next;
        periodic_reg <= periodic_next;
        cb_reg       <= cb_next;
    end

endmodule

### src/multi_timer_manager.sv
// multi_timer_manager: pool of timers driven by tick items
// input channel: cmd carries one item, accepted on a clock edge with start high
// and busy low; busy stays high until the item's last result is issued
// result channel: res is valid for exactly one cycle while strobe is high;
// res.last marks the final result of an item; the receiver cannot stall
// create, start, stop, delete and query: decoded in S_EXEC after accept, one
// result each, next item taken in the cycle the result is shown
// tick: the counter steps, then every timer cell compares its match in
// parallel; hits are handed down the cell row as a priority chain and one
// expiry is reported per cycle in ascending id order
// tick steps: S_LOAD latches the hits; with none, a single result with last set
// is issued, else S_SCAN issues one result per expiry, the final one marked last
// reset: counter zero, all timers unused, free queue holds ids in order;
// no clearing pass is needed
module multi_timer_manager #(
    parameter int NUM_TIMERS = mtm_pkg::NUM_TIMERS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mtm_pkg::item_in_t   cmd,
    output logic                strobe,
    output mtm_pkg::item_res_t  res
);
    import mtm_pkg::*;

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);

    fsm_t        state_reg, state_next;
    item_in_t    in_reg, in_next;
    logic [31:0] count_reg, count_next;
    logic [NUM_TIMERS-1:0] hits_reg, hits_next;
    item_res_t   res_reg, res_next;
    logic        strobe_reg, strobe_next;

    logic [IW-1:0] fq_reg [NUM_TIMERS];
    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] fcnt_reg, fcnt_next;
    logic          push, pop;
    logic [IW:0]   tail_sum;
    logic [IW-1:0] tail;

    cell_cmd_t   ccmd;
    logic [NUM_TIMERS:0]   chain;
    logic [NUM_TIMERS-1:0] sel, hit, per_arr, cb_arr;
    logic [1:0]  st_arr [NUM_TIMERS];
    logic [31:0] match_arr [NUM_TIMERS];

    logic          id_ok;
    logic [IW-1:0] idx;
    logic [1:0]    cur_st;
    logic [31:0]   cur_match;
    logic          cur_cb;
    logic [IW-1:0] fire_id;
    logic          fire_per, fire_cb;

    assign chain[0] = 1'b0;

    for (genvar g = 0; g < NUM_TIMERS; g++)
    begin : g_cell
        mtm_cell #(.IDX(g)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (ccmd),
            .count    (count_reg),
            .pend     (hits_reg[g] && state_reg == S_SCAN),
            .prior_in (chain[g]),
            .prior_out(chain[g+1]),
            .sel      (sel[g]),
            .hit      (hit[g]),
            .st       (st_arr[g]),
            .match    (match_arr[g]),
            .periodic (per_arr[g]),
            .callback (cb_arr[g])
        );
    end

    assign id_ok     = 32'(in_reg.target_id) < NUM_TIMERS;
    assign idx       = IW'(in_reg.target_id);
    assign cur_st    = id_ok ? st_arr[idx] : TS_UNUSED;
    assign cur_match = match_arr[idx];
    assign cur_cb    = cb_arr[idx];

    always_comb
    begin
        fire_id  = '0;
        fire_per = 1'b0;
        fire_cb  = 1'b0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            if (sel[i])
            begin
                fire_id  = IW'(i);
                fire_per = per_arr[i];
                fire_cb  = cb_arr[i];
            end
        end
    end

    assign tail_sum = (IW+1)'(head_reg) + (IW+1)'(fcnt_reg);
    assign tail     = (tail_sum >= (IW+1)'(NUM_TIMERS)) ?
                      IW'(tail_sum - (IW+1)'(NUM_TIMERS)) : IW'(tail_sum);

    always_comb
    begin
        state_next  = state_reg;
        in_next     = in_reg;
        count_next  = count_reg;
        hits_next   = hits_reg;
        res_next    = '0;
        strobe_next = 1'b0;
        ccmd        = '0;
        ccmd.op     = OP_NOP;
        push        = 1'b0;
        pop         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    in_next = cmd;
                    if (cmd.kind == KIND_TICK)
                    begin
                        count_next = count_reg + 32'd1;
                        state_next = S_LOAD;
                    end
                    else
                        state_next = S_EXEC;
                end
            end
            S_LOAD:
            begin
                hits_next = hit;
                if (hit == '0)
                begin
                    res_next.last = 1'b1;
                    strobe_next   = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                ccmd.op   = OP_FIRE;
                hits_next = hits_reg & ~sel;
                res_next.timer_id_res = 4'(fire_id);
                res_next.timer_state  = fire_per ? TS_RUNNING : TS_COMPLETED;
                res_next.callback_use = {1'b0, fire_cb};
                res_next.fired        = 1'b1;
                res_next.last         = (hits_next == '0);
                strobe_next           = 1'b1;
                if (hits_next == '0)
                    state_next = S_IDLE;
            end
            S_EXEC:
            begin
                state_next    = S_IDLE;
                strobe_next   = 1'b1;
                res_next.last = 1'b1;
                ccmd.idx      = IDX_W'(idx);
                case (in_reg.kind)
                    KIND_CREATE:
                    begin
                        if (in_reg.mode_select > 2'd1)
                            res_next.status = STS_BAD_OPTION;
                        else if (fcnt_reg == '0)
                            res_next.status = STS_NONE_FREE;
                        else
                        begin
                            pop           = 1'b1;
                            ccmd.op       = OP_CREATE;
                            ccmd.idx      = IDX_W'(fq_reg[head_reg]);
                            ccmd.delay    = in_reg.delay;
                            ccmd.period   = in_reg.period;
                            ccmd.periodic = in_reg.mode_select[0];
                            ccmd.callback = in_reg.has_callback;
                            res_next.timer_id_res = 4'(fq_reg[head_reg]);
                            res_next.timer_state  = TS_STOPPED;
                        end
                    end
                    KIND_START:
                    begin
                        res_next.timer_id_res = in_reg.target_id;
                        if (cur_st == TS_UNUSED)
                            res_next.status = STS_UNUSED;
                        else
                        begin
                            ccmd.op = OP_START;
                            res_next.timer_state = TS_RUNNING;
                        end
                    end
                    KIND_STOP:
                    begin
                        res_next.timer_id_res = in_reg.target_id;
                        res_next.timer_state  = cur_st;
                        if (cur_st == TS_UNUSED)
                            res_next.status = STS_UNUSED;
                        else if (cur_st != TS_RUNNING)
                            res_next.status = STS_NOT_RUNNING;
                        else if (in_reg.stop_option == OPT_NONE)
                            res_next.status = STS_BAD_OPTION;
                        else if (in_reg.stop_option != OPT_NO_CB && !cur_cb)
                            res_next.status = STS_NO_CALLBACK;
                        else
                        begin
                            ccmd.op = OP_STOP;
                            res_next.timer_state  = TS_STOPPED;
                            res_next.callback_use = in_reg.stop_option - 2'd1;
                        end
                    end
                    KIND_DELETE:
                    begin
                        res_next.timer_id_res = in_reg.target_id;
                        if (cur_st == TS_UNUSED)
                            res_next.status = STS_UNUSED;
                        else
                        begin
                            ccmd.op = OP_DELETE;
                            push    = (fcnt_reg < CW'(NUM_TIMERS));
                            res_next.timer_state = TS_UNUSED;
                        end
                    end
                    KIND_QUERY:
                    begin
                        res_next.timer_id_res = in_reg.target_id;
                        res_next.timer_state  = cur_st;
                        if (cur_st == TS_UNUSED)
                            res_next.status = STS_UNUSED;
                        else if (cur_st != TS_RUNNING)
                            res_next.status = STS_NOT_RUNNING;
                        else if (cur_match >= count_reg)
                            res_next.remaining = cur_match - count_reg;
                        else
                            res_next.remaining = count_reg - cur_match;
                    end
                    default:
                        res_next.status = STS_BAD_OPTION;
                endcase
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        head_next = head_reg;
        fcnt_next = fcnt_reg;
        if (pop)
        begin
            head_next = (32'(head_reg) == NUM_TIMERS - 1) ? '0 : head_reg + IW'(1);
            fcnt_next = fcnt_reg - CW'(1);
        end
        else if (push)
            fcnt_next = fcnt_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
            head_reg   <= '0;
            fcnt_reg   <= CW'(NUM_TIMERS);
            for (int i = 0; i < NUM_TIMERS; i++)
                fq_reg[i] <= IW'(i);
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
            head_reg   <= head_next;
            fcnt_reg   <= fcnt_next;
            if (push)
                fq_reg[tail] <= idx;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg   <= in_next;
        hits_reg <= hits_next;
        res_reg  <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign res    = res_reg;

`include "multi_timer_manager_macros.svh"

    `MTM_ASSERT_NOW(a_fcnt_range, 1'b1, fcnt_reg <= CW'(NUM_TIMERS), "free count overflow")
    `MTM_ASSERT_NOW(a_one_fire, state_reg == S_SCAN, $onehot(sel), "scan without single select")
    `MTM_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item not busy")
    `MTM_ASSERT_NXT(a_last_idle, strobe_next && res_next.last, state_reg == S_IDLE,
        "last result but still busy")

endmodule
